// ===== hdl/spst_pkg.sv =====
// ----------------------------------------------------------------------------
// spst_pkg
// Shared types, codes and constants for the sonar proximity stop block.
// ----------------------------------------------------------------------------
package spst_pkg;

   // Field widths
   localparam int DistWidth    = 8;
   localparam int TrigWidth    = 8;
   localparam int TimeoutWidth = 16;
   localparam int SpeedWidth   = 16;
   localparam int CsrDataWidth = 16;
   localparam int CsrIdxWidth  = 2;

   // Trigger widening while a stop is active
   localparam logic [TrigWidth:0] TrigWiden = (TrigWidth + 1)'(7);

   // Register reset values
   localparam logic [TrigWidth-1:0]    FrontTrigReset = TrigWidth'(25);
   localparam logic [TrigWidth-1:0]    BackTrigReset  = TrigWidth'(25);
   localparam logic [TimeoutWidth-1:0] TimeoutReset   = TimeoutWidth'(2);

   // Register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_FRONT_TRIGGER = 2'd0,
      CSR_BACK_TRIGGER  = 2'd1,
      CSR_STOP_TIMEOUT  = 2'd2
   } csr_idx_type;

   // Input opcodes
   typedef enum logic [1:0] {
      OP_SONAR = 2'd0,
      OP_SPEED = 2'd1,
      OP_TICK  = 2'd2,
      OP_DONE  = 2'd3
   } op_type;

   // Result event codes
   typedef enum logic [2:0] {
      EV_SET    = 3'd0,
      EV_CLEAR  = 3'd1,
      EV_ESCAPE = 3'd2,
      EV_DONE   = 3'd3,
      EV_PAUSED = 3'd4
   } evt_type;

   // Travel direction
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_BACK = 2'd2
   } dir_type;

   // Configuration register set
   typedef struct packed {
      logic [TrigWidth-1:0]    front_trigger;
      logic [TrigWidth-1:0]    back_trigger;
      logic [TimeoutWidth-1:0] stop_timeout_ticks;
   } cfg_type;

   // Input item
   typedef struct packed {
      logic [1:0]                   opcode;
      logic [DistWidth-1:0]         range_front_left;
      logic [DistWidth-1:0]         range_front_right;
      logic [DistWidth-1:0]         range_back_left;
      logic [DistWidth-1:0]         range_back_right;
      logic signed [SpeedWidth-1:0] drive_speed;
   } req_item_type;

   // Result item
   typedef struct packed {
      logic [2:0] event_res;
      logic       escape_forward;
      logic       front_blocked;
      logic       rear_blocked;
   } rsp_item_type;

   // Core to result register: load strobe and item
   typedef struct packed {
      logic         load;
      rsp_item_type item;
   } rsp_load_type;

endpackage

// ===== hdl/spst_req_if.sv =====
// ----------------------------------------------------------------------------
// spst_req_if
// Input channel: valid/ready handshake with the input item fields.
// ----------------------------------------------------------------------------
interface spst_req_if;

   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             opcode;
   logic [spst_pkg::DistWidth-1:0]         range_front_left;
   logic [spst_pkg::DistWidth-1:0]         range_front_right;
   logic [spst_pkg::DistWidth-1:0]         range_back_left;
   logic [spst_pkg::DistWidth-1:0]         range_back_right;
   logic signed [spst_pkg::SpeedWidth-1:0] drive_speed;

   modport source (
      output valid, opcode, range_front_left, range_front_right,
             range_back_left, range_back_right, drive_speed,
      input  ready
   );

   modport sink (
      input  valid, opcode, range_front_left, range_front_right,
             range_back_left, range_back_right, drive_speed,
      output ready
   );

endinterface

// ===== hdl/spst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// spst_rsp_if
// Result channel: valid/ready handshake with the result item fields.
// ----------------------------------------------------------------------------
interface spst_rsp_if;

   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic       escape_forward;
   logic       front_blocked;
   logic       rear_blocked;

   modport source (
      output valid, event_res, escape_forward, front_blocked, rear_blocked,
      input  ready
   );

   modport sink (
      input  valid, event_res, escape_forward, front_blocked, rear_blocked,
      output ready
   );

endinterface

// ===== hdl/sonar_proximity_stop.sv =====
// ----------------------------------------------------------------------------
// sonar_proximity_stop
// Proximity stop supervisor: sonar, speed, tick and order-complete items in,
// set/clear/escape/done/paused events out.
// ----------------------------------------------------------------------------
// Every item is registered at the input, decided in one pass of short logic
// (four 9-bit compares, a 16-bit timer decrement) and its event, if any, is
// written to a one-entry result register. The block takes one item per clock
// cycle unless stalled; each event passes the input register and then the
// result register. Only an item that makes an event waits on the result
// register, so input transfers stall only while a result is held and not
// taken. Configuration writes are registered and should be made while the
// block is idle.
// ----------------------------------------------------------------------------
module sonar_proximity_stop (
   input  logic                              clock,
   input  logic                              reset,
   spst_req_if.sink                          req_chan,
   spst_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [spst_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [spst_pkg::CsrDataWidth-1:0] csr_wdata
);

   spst_pkg::cfg_type      cfg;
   spst_pkg::rsp_load_type rsp_load;
   logic                   slot_free;

   // Configuration registers
   spst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Decision logic and state
   spst_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cfg       (cfg),
      .slot_free (slot_free),
      .rsp_load  (rsp_load)
   );

   // Result register
   spst_out u_out (
      .clock     (clock),
      .reset     (reset),
      .rsp_load  (rsp_load),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

   // An empty result register never stalls the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("input stalled with empty result register");

   // A stop can only be set with a blocked side
   a_set_has_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.event_res == spst_pkg::EV_SET) |->
         (rsp_chan.front_blocked || rsp_chan.rear_blocked))
      else $error("stop set with no side blocked");

   // Escape goes away from the front obstacle; other events carry no direction
   a_escape_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         (rsp_chan.escape_forward ==
          ((rsp_chan.event_res == spst_pkg::EV_ESCAPE) && !rsp_chan.front_blocked)))
      else $error("escape direction mismatch");

   // An escape never happens when boxed in on both sides
   a_escape_not_boxed: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.event_res == spst_pkg::EV_ESCAPE) |->
         !(rsp_chan.front_blocked && rsp_chan.rear_blocked))
      else $error("escape with both sides blocked");

endmodule

// ===== hdl/spst_csr.sv =====
// ----------------------------------------------------------------------------
// spst_csr
// Configuration registers: trigger distances and stop timeout.
// ----------------------------------------------------------------------------
module spst_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [spst_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [spst_pkg::CsrDataWidth-1:0]    csr_wdata,
   output spst_pkg::cfg_type                    cfg
);

   spst_pkg::cfg_type cfg_ff;
   spst_pkg::cfg_type cfg_in;

   // Decode the write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            spst_pkg::CSR_FRONT_TRIGGER:
               cfg_in.front_trigger = csr_wdata[spst_pkg::TrigWidth-1:0];
            spst_pkg::CSR_BACK_TRIGGER:
               cfg_in.back_trigger = csr_wdata[spst_pkg::TrigWidth-1:0];
            spst_pkg::CSR_STOP_TIMEOUT:
               cfg_in.stop_timeout_ticks = csr_wdata[spst_pkg::TimeoutWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.front_trigger      <= spst_pkg::FrontTrigReset;
         cfg_ff.back_trigger       <= spst_pkg::BackTrigReset;
         cfg_ff.stop_timeout_ticks <= spst_pkg::TimeoutReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/spst_core.sv =====
// ----------------------------------------------------------------------------
// spst_core
// Input register, stop supervisor state and the single-pass decision logic.
// ----------------------------------------------------------------------------
module spst_core (
   input  logic                   clock,
   input  logic                   reset,
   spst_req_if.sink               req_chan,
   input  spst_pkg::cfg_type      cfg,
   input  logic                   slot_free,
   output spst_pkg::rsp_load_type rsp_load
);

   // Input register
   logic                    in_vld_ff;
   logic                    in_vld_in;
   spst_pkg::req_item_type  in_item_ff;

   // Supervisor state
   logic                                stop_active_ff, stop_active_in;
   logic                                front_flag_ff, front_flag_in;
   logic                                rear_flag_ff, rear_flag_in;
   spst_pkg::dir_type                   travel_dir_ff, travel_dir_in;
   logic [spst_pkg::TimeoutWidth-1:0]   timer_count_ff, timer_count_in;
   logic                                timer_armed_ff, timer_armed_in;
   logic                                escaped_flag_ff, escaped_flag_in;

   // Decision signals
   logic                               has_res;
   spst_pkg::rsp_item_type             res_item;
   logic                               advance;
   logic                               accept;
   logic [spst_pkg::TrigWidth:0]       widen;
   logic [spst_pkg::TrigWidth:0]       front_lim;
   logic [spst_pkg::TrigWidth:0]       back_lim;
   logic                               front_hit;
   logic                               rear_hit;
   logic                               stop_hit;

   // Widened trigger compares (9 bits, never wrap)
   always_comb begin
      widen     = stop_active_ff ? spst_pkg::TrigWiden : '0;
      front_lim = {1'b0, cfg.front_trigger} + widen;
      back_lim  = {1'b0, cfg.back_trigger} + widen;
      front_hit = ({1'b0, in_item_ff.range_front_left} <= front_lim) ||
                  ({1'b0, in_item_ff.range_front_right} <= front_lim);
      rear_hit  = ({1'b0, in_item_ff.range_back_left} <= back_lim) ||
                  ({1'b0, in_item_ff.range_back_right} <= back_lim);
      stop_hit  = ((travel_dir_ff == spst_pkg::DIR_FWD) && front_hit) ||
                  ((travel_dir_ff == spst_pkg::DIR_BACK) && rear_hit);
   end

   // Next state and result for the item in the input register
   always_comb begin
      stop_active_in  = stop_active_ff;
      front_flag_in   = front_flag_ff;
      rear_flag_in    = rear_flag_ff;
      travel_dir_in   = travel_dir_ff;
      timer_count_in  = timer_count_ff;
      timer_armed_in  = timer_armed_ff;
      escaped_flag_in = escaped_flag_ff;
      has_res         = 1'b0;
      res_item.event_res      = spst_pkg::EV_SET;
      res_item.escape_forward = 1'b0;

      unique case (spst_pkg::op_type'(in_item_ff.opcode))
         spst_pkg::OP_SONAR: begin
            front_flag_in  = front_hit;
            rear_flag_in   = rear_hit;
            stop_active_in = stop_hit;
            if (stop_hit != stop_active_ff) begin
               has_res = 1'b1;
               if (stop_hit) begin
                  timer_count_in     = cfg.stop_timeout_ticks;
                  timer_armed_in     = 1'b1;
                  res_item.event_res = spst_pkg::EV_SET;
               end else begin
                  timer_armed_in     = 1'b0;
                  res_item.event_res = spst_pkg::EV_CLEAR;
               end
            end
         end
         spst_pkg::OP_SPEED: begin
            if (in_item_ff.drive_speed[spst_pkg::SpeedWidth-1]) begin
               travel_dir_in = spst_pkg::DIR_BACK;
            end else if (in_item_ff.drive_speed != '0) begin
               travel_dir_in = spst_pkg::DIR_FWD;
            end else if (!stop_active_ff) begin
               travel_dir_in = spst_pkg::DIR_NONE;
            end
         end
         spst_pkg::OP_TICK: begin
            if (timer_armed_ff) begin
               if (timer_count_ff > spst_pkg::TimeoutWidth'(1)) begin
                  timer_count_in = timer_count_ff - spst_pkg::TimeoutWidth'(1);
               end else if (front_flag_ff && rear_flag_ff) begin
                  // Boxed in on both sides: re-arm
                  timer_count_in = cfg.stop_timeout_ticks;
                  timer_armed_in = 1'b1;
               end else begin
                  timer_count_in          = '0;
                  timer_armed_in          = 1'b0;
                  escaped_flag_in         = 1'b1;
                  has_res                 = 1'b1;
                  res_item.event_res      = spst_pkg::EV_ESCAPE;
                  res_item.escape_forward = !front_flag_ff;
               end
            end
         end
         spst_pkg::OP_DONE: begin
            timer_armed_in     = 1'b0;
            has_res            = 1'b1;
            res_item.event_res = escaped_flag_ff ? spst_pkg::EV_PAUSED
                                                 : spst_pkg::EV_DONE;
         end
         default: ;
      endcase

      res_item.front_blocked = front_flag_in;
      res_item.rear_blocked  = rear_flag_in;
   end

   // Advance when the item makes no result or the result slot can take one
   assign advance  = in_vld_ff && (!has_res || slot_free);
   assign req_chan.ready = !in_vld_ff || advance;
   assign accept   = req_chan.valid && req_chan.ready;
   assign in_vld_in = accept || (in_vld_ff && !advance);

   assign rsp_load.load = advance && has_res;
   assign rsp_load.item = res_item;

   // Input register control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   // Input register payload: load on transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.opcode            <= req_chan.opcode;
         in_item_ff.range_front_left  <= req_chan.range_front_left;
         in_item_ff.range_front_right <= req_chan.range_front_right;
         in_item_ff.range_back_left   <= req_chan.range_back_left;
         in_item_ff.range_back_right  <= req_chan.range_back_right;
         in_item_ff.drive_speed       <= req_chan.drive_speed;
      end
   end

   // Supervisor state: update as the item leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_active_ff  <= 1'b0;
         front_flag_ff   <= 1'b0;
         rear_flag_ff    <= 1'b0;
         travel_dir_ff   <= spst_pkg::DIR_NONE;
         timer_count_ff  <= '0;
         timer_armed_ff  <= 1'b0;
         escaped_flag_ff <= 1'b0;
      end else if (advance) begin
         stop_active_ff  <= stop_active_in;
         front_flag_ff   <= front_flag_in;
         rear_flag_ff    <= rear_flag_in;
         travel_dir_ff   <= travel_dir_in;
         timer_count_ff  <= timer_count_in;
         timer_armed_ff  <= timer_armed_in;
         escaped_flag_ff <= escaped_flag_in;
      end
   end

endmodule

// ===== hdl/spst_out.sv =====
// ----------------------------------------------------------------------------
// spst_out
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module spst_out (
   input  logic                   clock,
   input  logic                   reset,
   input  spst_pkg::rsp_load_type rsp_load,
   output logic                   slot_free,
   spst_rsp_if.source             rsp_chan
);

   logic                   res_vld_ff;
   logic                   res_vld_in;
   spst_pkg::rsp_item_type res_item_ff;

   // Slot frees when empty or when the held result transfers this cycle
   assign slot_free  = !res_vld_ff || rsp_chan.ready;
   assign res_vld_in = rsp_load.load || (res_vld_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         res_vld_ff <= 1'b0;
      end else begin
         res_vld_ff <= res_vld_in;
      end
   end

   // Capture a new result
   always_ff @(posedge clock) begin
      if (rsp_load.load) begin
         res_item_ff <= rsp_load.item;
      end
   end

   assign rsp_chan.valid          = res_vld_ff;
   assign rsp_chan.event_res      = res_item_ff.event_res;
   assign rsp_chan.escape_forward = res_item_ff.escape_forward;
   assign rsp_chan.front_blocked  = res_item_ff.front_blocked;
   assign rsp_chan.rear_blocked   = res_item_ff.rear_blocked;

endmodule
